>>> rtl/cicd_pkg.sv
// shared types and constants for the complex cic decimator
package cicd_pkg;

  // register field widths
  localparam int NUM_STAGES_W   = 3;
  localparam int DECIM_FACTOR_W = 7;
  localparam int SCALE_W        = 41;
  localparam int SCALE_FRAC     = 40;
  localparam int SCALE_LO_W     = 20;
  localparam int SCALE_HI_W     = SCALE_W - SCALE_LO_W;

  // clamped stage count, wide enough for up to eight stages
  localparam int STAGE_W = 4;

  // output counter width
  localparam int COUNT_W = 32;

  // configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_IDX_W  = 2;

  // register indexes (byte address is 8 times the index)
  localparam logic [CFG_IDX_W-1:0] REG_NUM_STAGES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECIM_FACTOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORM_SCALE   = 2'd2;

  // reset values
  localparam logic [NUM_STAGES_W-1:0]   NUM_STAGES_RESET   = 3'd1;
  localparam logic [DECIM_FACTOR_W-1:0] DECIM_FACTOR_RESET = 7'd1;
  localparam logic [SCALE_W-1:0]        SCALE_RESET        = 41'h100_0000_0000;

  // settings that every datapath section sees
  typedef struct packed {
    logic               clear;
    logic [STAGE_W-1:0] stages;
    logic [SCALE_W-1:0] scale;
  } ctrl_t;

endpackage

>>> rtl/cic_decimator_iq.sv
// top level of the complex cic decimator with gain correction
//
// Complex CIC decimator: each I/Q pair runs through num_stages integrators
// and, on every decim_factor-th pair, through num_stages combs; the comb
// output is multiplied by norm_scale / 2^40, rounded and saturated to the
// sample width and sent out with a running 32-bit output count. The block
// takes one input pair per clock while s_tready is high; backpressure and
// clearing writes hold it off. Every integrator, comb and normalize step
// is its own register stage, with one adder per cascade stage and the
// multiplier split into four partial products; empty stages collapse, so
// input is taken while a result waits as long as some stage is free.
// Registers sit at byte addresses 0 (num_stages), 8 (decim_factor) and
// 16 (norm_scale); any write to them flushes the pipeline and clears all
// filter state and the output count. Stage and ratio values out of range
// are clamped to 1..MAX_STAGES and 1..MAX_RATIO.
module cic_decimator_iq #(
  parameter int MAX_STAGES   = 5,
  parameter int MAX_RATIO    = 64,
  parameter int SAMPLE_WIDTH = 16,
  parameter int ACC_WIDTH    = 46
) (
  input  logic                                       clk,
  input  logic                                       rst,
  // configuration port
  input  logic                                       psel,
  input  logic                                       penable,
  input  logic                                       pwrite,
  input  logic [cicd_pkg::CFG_ADDR_W-1:0]            paddr,
  input  logic [cicd_pkg::CFG_DATA_W-1:0]            pwdata,
  output logic [cicd_pkg::CFG_DATA_W-1:0]            prdata,
  output logic                                       pready,
  // input samples
  input  logic                                       s_tvalid,
  output logic                                       s_tready,
  // s_tdata: sample_i, sample_q
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]        s_tdata,
  // output samples
  output logic                                       m_tvalid,
  input  logic                                       m_tready,
  // m_tdata: out_i, out_q, outputs_total
  output logic [((2*SAMPLE_WIDTH+32+7)/8)*8-1:0]     m_tdata
);

  localparam int OUT_TW = ((2*SAMPLE_WIDTH+32+7)/8)*8;
  localparam int RW     = $clog2(MAX_RATIO + 1);
  localparam int RCW    = (RW > cicd_pkg::DECIM_FACTOR_W) ? RW : cicd_pkg::DECIM_FACTOR_W;
  localparam int CMPW   = RCW + 1;
  localparam int PCW    = $clog2(MAX_RATIO);
  localparam int SW     = SAMPLE_WIDTH;

  logic [cicd_pkg::NUM_STAGES_W-1:0]   stages_reg;
  logic [cicd_pkg::DECIM_FACTOR_W-1:0] ratio_reg;
  logic [cicd_pkg::SCALE_W-1:0]        scale_reg;
  logic [cicd_pkg::CFG_IDX_W-1:0]      cfg_idx;
  logic                                cfg_wr;
  logic                                cfg_clear;
  logic [cicd_pkg::STAGE_W-1:0]        stages_eff;
  logic [RCW-1:0]                      ratio_eff;
  logic [PCW-1:0]                      phase;
  logic                                phase_last;
  logic                                in_accept;
  cicd_pkg::ctrl_t                     ctrl;

  logic [1:0][ACC_WIDTH-1:0] in_wide;
  logic                      int_in_ready;
  logic                      int_out_valid;
  logic                      int_out_ready;
  logic                      int_out_dec;
  logic [1:0][ACC_WIDTH-1:0] int_out_data;
  logic                      comb_in_ready;
  logic                      comb_out_valid;
  logic                      comb_out_ready;
  logic [1:0][ACC_WIDTH-1:0] comb_out_data;
  logic [1:0][SW-1:0]        res;
  logic [cicd_pkg::COUNT_W-1:0] res_total;

  // register write decode
  assign cfg_idx = paddr[cicd_pkg::CFG_ADDR_W-1:3];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    case (cfg_idx)
      cicd_pkg::REG_NUM_STAGES,
      cicd_pkg::REG_DECIM_FACTOR,
      cicd_pkg::REG_NORM_SCALE: cfg_clear = cfg_wr;
      default:                  cfg_clear = 1'b0;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stages_reg <= cicd_pkg::NUM_STAGES_RESET;
      ratio_reg  <= cicd_pkg::DECIM_FACTOR_RESET;
      scale_reg  <= cicd_pkg::SCALE_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        cicd_pkg::REG_NUM_STAGES:   stages_reg <= pwdata[cicd_pkg::NUM_STAGES_W-1:0];
        cicd_pkg::REG_DECIM_FACTOR: ratio_reg  <= pwdata[cicd_pkg::DECIM_FACTOR_W-1:0];
        cicd_pkg::REG_NORM_SCALE:   scale_reg  <= pwdata[cicd_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    prdata = '0;
    case (cfg_idx)
      cicd_pkg::REG_NUM_STAGES:   prdata[cicd_pkg::NUM_STAGES_W-1:0]   = stages_reg;
      cicd_pkg::REG_DECIM_FACTOR: prdata[cicd_pkg::DECIM_FACTOR_W-1:0] = ratio_reg;
      cicd_pkg::REG_NORM_SCALE:   prdata[cicd_pkg::SCALE_W-1:0]        = scale_reg;
      default: ;
    endcase
  end

  // clamp stage count and ratio to the supported range
  always_comb begin
    if (stages_reg == '0) begin
      stages_eff = cicd_pkg::STAGE_W'(1);
    end else if (cicd_pkg::STAGE_W'(stages_reg) > cicd_pkg::STAGE_W'(MAX_STAGES)) begin
      stages_eff = cicd_pkg::STAGE_W'(MAX_STAGES);
    end else begin
      stages_eff = cicd_pkg::STAGE_W'(stages_reg);
    end
    if (ratio_reg == '0) begin
      ratio_eff = RCW'(1);
    end else if (RCW'(ratio_reg) > RCW'(MAX_RATIO)) begin
      ratio_eff = RCW'(MAX_RATIO);
    end else begin
      ratio_eff = RCW'(ratio_reg);
    end
  end

  assign ctrl.clear  = cfg_clear;
  assign ctrl.stages = stages_eff;
  assign ctrl.scale  = scale_reg;

  // input transfer, held off for the cycle of a clearing write
  assign s_tready  = int_in_ready && !cfg_clear;
  assign in_accept = s_tvalid && s_tready;

  // decimation phase: tag the sample that completes a ratio period
  assign phase_last = (CMPW'(phase) + CMPW'(1)) >= CMPW'(ratio_eff);

  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      phase <= '0;
    end else if (in_accept) begin
      phase <= phase_last ? '0 : (phase + PCW'(1));
    end
  end

  // sign extend the samples to accumulator width
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      in_wide[c] = ACC_WIDTH'({{ACC_WIDTH{s_tdata[c*SW+SW-1]}}, s_tdata[c*SW +: SW]});
    end
  end

  cicd_integ #(
    .MAX_STAGES (MAX_STAGES),
    .ACC_WIDTH  (ACC_WIDTH)
  ) u_integ (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .in_valid  (s_tvalid && !cfg_clear),
    .in_ready  (int_in_ready),
    .in_dec    (phase_last),
    .in_data   (in_wide),
    .out_valid (int_out_valid),
    .out_ready (int_out_ready),
    .out_dec   (int_out_dec),
    .out_data  (int_out_data)
  );

  // samples between decimation points leave the pipeline here
  assign int_out_ready = !int_out_dec || comb_in_ready;

  cicd_comb #(
    .MAX_STAGES (MAX_STAGES),
    .ACC_WIDTH  (ACC_WIDTH)
  ) u_comb (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .in_valid  (int_out_valid && int_out_dec),
    .in_ready  (comb_in_ready),
    .in_data   (int_out_data),
    .out_valid (comb_out_valid),
    .out_ready (comb_out_ready),
    .out_data  (comb_out_data)
  );

  cicd_norm #(
    .ACC_WIDTH    (ACC_WIDTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_norm (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .in_valid  (comb_out_valid),
    .in_ready  (comb_out_ready),
    .in_data   (comb_out_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res),
    .out_total (res_total)
  );

  // pack the result, zero fill to whole bytes
  assign m_tdata = OUT_TW'({res_total, res[1], res[0]});

endmodule

>>> rtl/cicd_integ.sv
// pipelined integrator cascade for the i and q channels
module cicd_integ #(
  parameter int MAX_STAGES = 5,
  parameter int ACC_WIDTH  = 46
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cicd_pkg::ctrl_t           ctrl,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_dec,
  input  logic [1:0][ACC_WIDTH-1:0] in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_dec,
  output logic [1:0][ACC_WIDTH-1:0] out_data
);

  logic [MAX_STAGES:0]       rdy;
  logic [MAX_STAGES:0]       vin;
  logic [MAX_STAGES:0]       decin;
  logic [1:0][ACC_WIDTH-1:0] din [MAX_STAGES+1];

  assign rdy[MAX_STAGES] = out_ready;
  assign vin[0]          = in_valid;
  assign decin[0]        = in_dec;
  assign din[0]          = in_data;

  generate
    for (genvar j = 0; j < MAX_STAGES; j++) begin : g_stage
      logic                      v_r;
      logic                      dec_r;
      logic [1:0][ACC_WIDTH-1:0] acc;
      logic                      used;

      // stage takes part only below the configured count
      assign used = (j < int'(ctrl.stages));

      // a stage can take a new item when empty or when its item moves on
      assign rdy[j]     = !v_r || rdy[j+1];
      assign vin[j+1]   = v_r;
      assign decin[j+1] = dec_r;
      assign din[j+1]   = acc;

      // accumulator doubles as the stage output register
      always_ff @(posedge clk) begin
        if (rst || ctrl.clear) begin
          v_r <= 1'b0;
          acc <= '0;
        end else begin
          if (rdy[j]) begin
            v_r <= vin[j];
          end
          if (rdy[j] && vin[j]) begin
            for (int c = 0; c < 2; c++) begin
              acc[c] <= used ? (acc[c] + din[j][c]) : din[j][c];
            end
          end
        end
      end

      // decimation tag rides along
      always_ff @(posedge clk) begin
        if (rdy[j] && vin[j]) begin
          dec_r <= decin[j];
        end
      end
    end
  endgenerate

  assign in_ready  = rdy[0];
  assign out_valid = vin[MAX_STAGES];
  assign out_dec   = decin[MAX_STAGES];
  assign out_data  = din[MAX_STAGES];

endmodule

>>> rtl/cicd_comb.sv
// pipelined comb (difference) cascade for the i and q channels
module cicd_comb #(
  parameter int MAX_STAGES = 5,
  parameter int ACC_WIDTH  = 46
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cicd_pkg::ctrl_t           ctrl,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0][ACC_WIDTH-1:0] in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0][ACC_WIDTH-1:0] out_data
);

  logic [MAX_STAGES:0]       rdy;
  logic [MAX_STAGES:0]       vin;
  logic [1:0][ACC_WIDTH-1:0] din [MAX_STAGES+1];

  assign rdy[MAX_STAGES] = out_ready;
  assign vin[0]          = in_valid;
  assign din[0]          = in_data;

  generate
    for (genvar j = 0; j < MAX_STAGES; j++) begin : g_stage
      logic                      v_r;
      logic [1:0][ACC_WIDTH-1:0] dly;
      logic [1:0][ACC_WIDTH-1:0] dat;
      logic                      used;

      assign used = (j < int'(ctrl.stages));

      assign rdy[j]   = !v_r || rdy[j+1];
      assign vin[j+1] = v_r;
      assign din[j+1] = dat;

      // valid flag and delay line state
      always_ff @(posedge clk) begin
        if (rst || ctrl.clear) begin
          v_r <= 1'b0;
          dly <= '0;
        end else begin
          if (rdy[j]) begin
            v_r <= vin[j];
          end
          if (rdy[j] && vin[j] && used) begin
            dly <= din[j];
          end
        end
      end

      // difference against the previous decimated value
      always_ff @(posedge clk) begin
        if (rdy[j] && vin[j]) begin
          for (int c = 0; c < 2; c++) begin
            dat[c] <= used ? (din[j][c] - dly[c]) : din[j][c];
          end
        end
      end
    end
  endgenerate

  assign in_ready  = rdy[0];
  assign out_valid = vin[MAX_STAGES];
  assign out_data  = din[MAX_STAGES];

endmodule

>>> rtl/cicd_norm.sv
// gain correction: scale, round, saturate and count the outputs
module cicd_norm #(
  parameter int ACC_WIDTH    = 46,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  cicd_pkg::ctrl_t                    ctrl,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0][ACC_WIDTH-1:0]          in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0][SAMPLE_WIDTH-1:0]       out_data,
  output logic [cicd_pkg::COUNT_W-1:0]       out_total
);

  localparam int SL_W = cicd_pkg::SCALE_LO_W;
  localparam int SH_W = cicd_pkg::SCALE_HI_W;
  localparam int SC_W = cicd_pkg::SCALE_W;
  localparam int FR_W = cicd_pkg::SCALE_FRAC;
  localparam int ML_W = (ACC_WIDTH + 1) / 2;
  localparam int MH_W = ACC_WIDTH - ML_W;
  localparam int LL_W = ML_W + SL_W;
  localparam int LH_W = ML_W + SH_W;
  localparam int HL_W = MH_W + SL_W;
  localparam int HH_W = MH_W + SH_W;
  localparam int LO_W = ML_W + SC_W;
  localparam int HI_W = MH_W + SC_W;
  localparam int P_W  = ACC_WIDTH + SC_W + 1;
  localparam int Q_W  = P_W - FR_W;
  localparam int C_W  = Q_W + SAMPLE_WIDTH;

  localparam logic [P_W-1:0] RND     = P_W'(1) << (FR_W - 1);
  localparam logic [C_W-1:0] LIM_NEG = C_W'(1) << (SAMPLE_WIDTH - 1);
  localparam logic [C_W-1:0] LIM_POS = LIM_NEG - C_W'(1);

  logic rdy0, rdy1, rdy2, rdy3, rdy4;
  logic v0, v1, v2, v3, v4;

  logic [1:0]                neg0, neg1, neg2, neg3;
  logic [1:0][ACC_WIDTH-1:0] mag0;
  logic [1:0][LL_W-1:0]      pll;
  logic [1:0][LH_W-1:0]      plh;
  logic [1:0][HL_W-1:0]      phl;
  logic [1:0][HH_W-1:0]      phh;
  logic [1:0][LO_W-1:0]      lo2;
  logic [1:0][HI_W-1:0]      hi2;
  logic [1:0][P_W-1:0]       p3;
  logic [1:0][C_W-1:0]       qx;
  logic [1:0][C_W-1:0]       lim;
  logic [1:0][C_W-1:0]       clip;
  logic [1:0][SAMPLE_WIDTH-1:0] clip_s;
  logic [1:0][SAMPLE_WIDTH-1:0] res_next;
  logic [1:0][SAMPLE_WIDTH-1:0] res;
  logic [cicd_pkg::COUNT_W-1:0] total;

  // backpressure through the stages, bubbles collapse
  assign rdy4     = !v4 || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign rdy0     = !v0 || rdy1;
  assign in_ready = rdy0;

  // valid flags and output counter
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      v0    <= 1'b0;
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      v4    <= 1'b0;
      total <= '0;
    end else begin
      if (rdy0) v0 <= in_valid;
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy4 && v3) begin
        total <= total + cicd_pkg::COUNT_W'(1);
      end
    end
  end

  // sign and magnitude; the most negative value maps to its own magnitude
  always_ff @(posedge clk) begin
    if (rdy0) begin
      for (int c = 0; c < 2; c++) begin
        neg0[c] <= in_data[c][ACC_WIDTH-1];
        mag0[c] <= in_data[c][ACC_WIDTH-1] ? (~in_data[c] + ACC_WIDTH'(1)) : in_data[c];
      end
    end
  end

  // four partial products per channel
  always_ff @(posedge clk) begin
    if (rdy1) begin
      neg1 <= neg0;
      for (int c = 0; c < 2; c++) begin
        pll[c] <= LL_W'(mag0[c][ML_W-1:0]) * LL_W'(ctrl.scale[SL_W-1:0]);
        plh[c] <= LH_W'(mag0[c][ML_W-1:0]) * LH_W'(ctrl.scale[SC_W-1:SL_W]);
        phl[c] <= HL_W'(mag0[c][ACC_WIDTH-1:ML_W]) * HL_W'(ctrl.scale[SL_W-1:0]);
        phh[c] <= HH_W'(mag0[c][ACC_WIDTH-1:ML_W]) * HH_W'(ctrl.scale[SC_W-1:SL_W]);
      end
    end
  end

  // combine products that share a magnitude half
  always_ff @(posedge clk) begin
    if (rdy2) begin
      neg2 <= neg1;
      for (int c = 0; c < 2; c++) begin
        lo2[c] <= LO_W'(pll[c]) + (LO_W'(plh[c]) << SL_W);
        hi2[c] <= HI_W'(phl[c]) + (HI_W'(phh[c]) << SL_W);
      end
    end
  end

  // full product plus half an lsb for round to nearest, ties away from zero
  always_ff @(posedge clk) begin
    if (rdy3) begin
      neg3 <= neg2;
      for (int c = 0; c < 2; c++) begin
        p3[c] <= P_W'(lo2[c]) + (P_W'(hi2[c]) << ML_W) + RND;
      end
    end
  end

  // saturate the magnitude and restore the sign
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      qx[c]       = C_W'(p3[c][P_W-1:FR_W]);
      lim[c]      = neg3[c] ? LIM_NEG : LIM_POS;
      clip[c]     = (qx[c] > lim[c]) ? lim[c] : qx[c];
      clip_s[c]   = clip[c][SAMPLE_WIDTH-1:0];
      res_next[c] = neg3[c] ? (~clip_s[c] + SAMPLE_WIDTH'(1)) : clip_s[c];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rdy4) begin
      res <= res_next;
    end
  end

  assign out_valid = v4;
  assign out_data  = res;
  assign out_total = total;

endmodule

>>> rtl/cicd_checker.sv
// port-level checks for the complex cic decimator, bound to the top level
module cicd_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   psel,
  input logic                                   penable,
  input logic                                   pwrite,
  input logic [cicd_pkg::CFG_ADDR_W-1:0]        paddr,
  input logic                                   pready,
  input logic                                   m_tvalid,
  input logic                                   m_tready,
  input logic [((2*SAMPLE_WIDTH+32+7)/8)*8-1:0] m_tdata
);

  localparam int TOT_LO = 2 * SAMPLE_WIDTH;

  logic [cicd_pkg::CFG_IDX_W-1:0] idx;
  logic                           wr_clear;
  logic                           m_xfer;
  logic [cicd_pkg::COUNT_W-1:0]   tot;
  logic [cicd_pkg::COUNT_W-1:0]   last_total;
  logic                           have_last;

  assign idx      = paddr[cicd_pkg::CFG_ADDR_W-1:3];
  assign wr_clear = psel && penable && pwrite && pready &&
                    (idx == cicd_pkg::REG_NUM_STAGES ||
                     idx == cicd_pkg::REG_DECIM_FACTOR ||
                     idx == cicd_pkg::REG_NORM_SCALE);
  assign m_xfer   = m_tvalid && m_tready;
  assign tot      = m_tdata[TOT_LO +: cicd_pkg::COUNT_W];

  // remember the count of the last output transfer since a clear
  always_ff @(posedge clk) begin
    if (rst || wr_clear) begin
      have_last <= 1'b0;
    end else if (m_xfer) begin
      have_last <= 1'b1;
    end
    if (m_xfer) begin
      last_total <= tot;
    end
  end

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // a stalled result holds unless a clearing write flushes it
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready && !wr_clear |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // first result after reset or a clearing write counts one
  a_first_count: assert property (@(posedge clk) disable iff (rst)
    m_xfer && !have_last |-> tot == cicd_pkg::COUNT_W'(1))
    else $error("first output count is not one");

  // later results count up by one per transfer
  a_next_count: assert property (@(posedge clk) disable iff (rst)
    m_xfer && have_last |-> tot == last_total + cicd_pkg::COUNT_W'(1))
    else $error("output count skipped or repeated");

endmodule

bind cic_decimator_iq cicd_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_chk (.*);
